[sv/cpt_pkg.sv]
// ============================================================================
// Contact plan table package
// Shared constants, transaction types and controller/datapath command types.
// ============================================================================
`default_nettype none

package cpt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int ENTRY_W     = 6;
    localparam int CMP_W       = ENTRY_W + 1;
    localparam int DIV_STEPS   = 32;
    localparam int DCNT_W      = 6;

    // opcodes
    localparam logic [2:0] OP_CLEAR   = 3'd0;
    localparam logic [2:0] OP_ADD     = 3'd1;
    localparam logic [2:0] OP_LOOKUP  = 3'd2;
    localparam logic [2:0] OP_LIST    = 3'd3;
    localparam logic [2:0] OP_RESERVE = 3'd4;
    localparam logic [2:0] OP_RELEASE = 3'd5;
    localparam logic [2:0] OP_CONSUME = 3'd6;
    localparam logic [2:0] OP_NONE    = 3'd7;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_BADIDX   = 2'd3;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [5:0]  entry_index;
        logic [15:0] source_node;
        logic [15:0] dest_node;
        logic [31:0] window_start;
        logic [31:0] window_end;
        logic [23:0] link_rate;
        logic [31:0] light_time;
        logic [31:0] now_time;
        logic [31:0] size_bytes;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status_code;
        logic [5:0]         found_index;
        logic               is_active;
        logic               is_future;
        logic               is_feasible;
        logic signed [47:0] usable_capacity;
        logic [31:0]        earliest_start;
        logic [31:0]        arrive_time;
        logic               last_result;
    } t_out_item;

    typedef struct packed {
        logic [15:0] src;
        logic [15:0] dst;
        logic [31:0] st;
        logic [31:0] en;
        logic [23:0] rt;
        logic [31:0] lt;
    } t_contact;

    typedef struct packed {
        logic [47:0] used;
        logic [47:0] rsv;
    } t_ctr;

    typedef enum logic [2:0] {
        IX_ZERO  = 3'd0,
        IX_COUNT = 3'd1,
        IX_ENTRY = 3'd2,
        IX_PEND  = 3'd3,
        IX_EVAL  = 3'd4
    } t_idx_sel;

    typedef struct packed {
        logic       load;
        logic       clr_count;
        logic       add_wr;
        logic       scan_clr;
        logic       scan_inc;
        logic       pend_set;
        logic       upd_wr;
        logic       eval_load;
        logic       stage;
        logic       stage_eval;
        logic [1:0] st_status;
        t_idx_sel   st_idx;
        logic       st_last;
        logic       emit;
    } t_cmd;

    typedef struct packed {
        logic [2:0] op;
        logic       full;
        logic       count_zero;
        logic       bad_idx;
        logic       match_pair;
        logic       match_src;
        logic       scan_last;
        logic       pend_v;
        logic       eval_done;
        logic       out_free;
    } t_stat;

endpackage

`default_nettype wire

[sv/cpt_ram.sv]
// ============================================================================
// Generic RAM
// One write port, one read port, registered read data.
// ============================================================================
`default_nettype none

module cpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[sv/cpt_dpath.sv]
// ============================================================================
// Contact plan table datapath
// Table RAMs, scan index, lookup arithmetic, divider, result and output regs.
// ============================================================================
`default_nettype none

module cpt_dpath (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire cpt_pkg::t_cmd     i_cmd,
    output cpt_pkg::t_stat         o_stat,
    input  wire cpt_pkg::t_in_item i_item,
    input  wire logic              i_out_stall,
    output logic                   o_out_valid,
    output cpt_pkg::t_out_item     o_out_item
);

    localparam logic signed [57:0] CAP_HI = 58'sd140737488355327;
    localparam logic signed [57:0] CAP_LO = -58'sd140737488355328;

    cpt_pkg::t_in_item  r_item;
    logic [cpt_pkg::CNT_W-1:0] r_count;
    logic [cpt_pkg::IDX_W-1:0] r_scan;
    logic                      r_pend_v;
    logic [cpt_pkg::IDX_W-1:0] r_pend_idx;

    cpt_pkg::t_contact ct_rd, ct_wr;
    cpt_pkg::t_ctr     cn_rd, cn_wr, upd;
    logic [cpt_pkg::IDX_W-1:0] rd_addr, cn_waddr, count_idx, entry_idx;
    logic upd_op;
    logic [48:0] sum_used, sum_rsv;
    logic [47:0] drop_rsv;

    // lookup evaluation
    logic [31:0] r_st, r_en, r_lt, r_now, r_size;
    logic [23:0] r_rt;
    logic [47:0] r_used, r_rsv;
    logic [cpt_pkg::IDX_W-1:0] r_eidx;
    logic [31:0] r_left, r_es;
    logic        r_act, r_fut, r_feas;
    logic [55:0] r_prod;
    logic signed [57:0] r_diff, r_cap;
    logic signed [47:0] r_capsat;
    logic [24:0] r_rem;
    logic [31:0] r_quo;
    logic [cpt_pkg::DCNT_W-1:0] r_dcnt;
    logic [31:0] r_arr;
    logic [24:0] trial;
    logic [33:0] arr_sum;

    cpt_pkg::t_out_item r_res;
    logic [cpt_pkg::ENTRY_W-1:0] st_idx;
    logic r_out_valid;

    assign count_idx = r_count[cpt_pkg::IDX_W-1:0];
    assign entry_idx = r_item.entry_index[cpt_pkg::IDX_W-1:0];
    assign upd_op    = (r_item.opcode == cpt_pkg::OP_RESERVE) ||
                       (r_item.opcode == cpt_pkg::OP_RELEASE) ||
                       (r_item.opcode == cpt_pkg::OP_CONSUME);
    assign rd_addr   = upd_op ? entry_idx : r_scan;

    assign ct_wr.src = r_item.source_node;
    assign ct_wr.dst = r_item.dest_node;
    assign ct_wr.st  = r_item.window_start;
    assign ct_wr.en  = r_item.window_end;
    assign ct_wr.rt  = r_item.link_rate;
    assign ct_wr.lt  = r_item.light_time;

    cpt_ram #(
        .WIDTH ($bits(cpt_pkg::t_contact)),
        .DEPTH (cpt_pkg::TABLE_DEPTH)
    ) u_contact_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.add_wr),
        .i_waddr (count_idx),
        .i_wdata (ct_wr),
        .i_raddr (rd_addr),
        .o_rdata (ct_rd)
    );

    // counter updates: saturating add, floored drop
    always_comb begin
        sum_used = {1'b0, cn_rd.used} + 49'(r_item.size_bytes);
        sum_rsv  = {1'b0, cn_rd.rsv} + 49'(r_item.size_bytes);
        drop_rsv = (cn_rd.rsv > 48'(r_item.size_bytes)) ?
                   cn_rd.rsv - 48'(r_item.size_bytes) : 48'd0;
        upd = cn_rd;
        case (r_item.opcode)
            cpt_pkg::OP_RESERVE: begin
                upd.rsv = sum_rsv[48] ? {48{1'b1}} : sum_rsv[47:0];
            end
            cpt_pkg::OP_RELEASE: begin
                upd.rsv = drop_rsv;
            end
            cpt_pkg::OP_CONSUME: begin
                upd.used = sum_used[48] ? {48{1'b1}} : sum_used[47:0];
                upd.rsv  = drop_rsv;
            end
            default: begin
                upd = cn_rd;
            end
        endcase
    end

    assign cn_wr    = i_cmd.add_wr ? '0 : upd;
    assign cn_waddr = i_cmd.add_wr ? count_idx : entry_idx;

    cpt_ram #(
        .WIDTH ($bits(cpt_pkg::t_ctr)),
        .DEPTH (cpt_pkg::TABLE_DEPTH)
    ) u_counter_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.add_wr | i_cmd.upd_wr),
        .i_waddr (cn_waddr),
        .i_wdata (cn_wr),
        .i_raddr (rd_addr),
        .o_rdata (cn_rd)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_scan   <= '0;
            r_pend_v <= 1'b0;
        end else begin
            if (i_cmd.clr_count) begin
                r_count <= '0;
            end else if (i_cmd.add_wr) begin
                r_count <= r_count + cpt_pkg::CNT_W'(1);
            end
            if (i_cmd.scan_clr) begin
                r_scan   <= '0;
                r_pend_v <= 1'b0;
            end else begin
                if (i_cmd.scan_inc) begin
                    r_scan <= r_scan + cpt_pkg::IDX_W'(1);
                end
                if (i_cmd.pend_set) begin
                    r_pend_v <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        if (i_cmd.pend_set) begin
            r_pend_idx <= r_scan;
        end
    end

    // lookup pipeline; settles well within the divider's run
    always_ff @(posedge i_clk) begin
        if (i_cmd.eval_load) begin
            r_st   <= ct_rd.st;
            r_en   <= ct_rd.en;
            r_rt   <= ct_rd.rt;
            r_lt   <= ct_rd.lt;
            r_used <= cn_rd.used;
            r_rsv  <= cn_rd.rsv;
            r_now  <= r_item.now_time;
            r_size <= r_item.size_bytes;
            r_eidx <= r_scan;
        end
        r_left   <= (r_en > r_now) ? r_en - r_now : 32'd0;
        r_act    <= (r_st <= r_now) && (r_now < r_en);
        r_fut    <= r_now < r_st;
        r_es     <= (r_now > r_st) ? r_now : r_st;
        r_prod   <= 56'(r_rt) * 56'(r_left);
        r_diff   <= $signed({2'b00, r_prod}) - $signed({10'd0, r_used});
        r_cap    <= r_diff - $signed({10'd0, r_rsv});
        r_feas   <= r_act && (r_cap >= $signed({26'd0, r_size}));
        r_capsat <= (r_cap > CAP_HI) ? CAP_HI[47:0] :
                    (r_cap < CAP_LO) ? CAP_LO[47:0] : r_cap[47:0];
    end

    // restoring divider, one quotient bit a cycle, then the arrival sum
    assign trial   = {r_rem[23:0], r_quo[31]} - {1'b0, r_rt};
    assign arr_sum = 34'(r_es) + 34'(r_quo) + 34'(r_lt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt <= '0;
        end else if (i_cmd.eval_load) begin
            r_dcnt <= cpt_pkg::DCNT_W'(cpt_pkg::DIV_STEPS + 1);
        end else if (r_dcnt != '0) begin
            r_dcnt <= r_dcnt - cpt_pkg::DCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval_load) begin
            r_rem <= '0;
            r_quo <= r_item.size_bytes;
        end else if (r_dcnt > cpt_pkg::DCNT_W'(1)) begin
            if (!trial[24]) begin
                r_rem <= trial;
                r_quo <= {r_quo[30:0], 1'b1};
            end else begin
                r_rem <= {r_rem[23:0], r_quo[31]};
                r_quo <= {r_quo[30:0], 1'b0};
            end
        end
        if (r_dcnt == cpt_pkg::DCNT_W'(1)) begin
            r_arr <= ((r_rt == '0) || (arr_sum[33:32] != 2'b00)) ? 32'hFFFF_FFFF
                                                                : arr_sum[31:0];
        end
    end

    // result staging
    always_comb begin
        case (i_cmd.st_idx)
            cpt_pkg::IX_ZERO:  st_idx = '0;
            cpt_pkg::IX_COUNT: st_idx = cpt_pkg::ENTRY_W'(count_idx);
            cpt_pkg::IX_ENTRY: st_idx = r_item.entry_index;
            cpt_pkg::IX_PEND:  st_idx = cpt_pkg::ENTRY_W'(r_pend_idx);
            cpt_pkg::IX_EVAL:  st_idx = cpt_pkg::ENTRY_W'(r_eidx);
            default:           st_idx = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.stage_eval) begin
            r_res.status_code     <= cpt_pkg::ST_OK;
            r_res.found_index     <= cpt_pkg::ENTRY_W'(r_eidx);
            r_res.is_active       <= r_act;
            r_res.is_future       <= r_fut;
            r_res.is_feasible     <= r_feas;
            r_res.usable_capacity <= r_capsat;
            r_res.earliest_start  <= r_es;
            r_res.arrive_time     <= r_arr;
            r_res.last_result     <= 1'b1;
        end else if (i_cmd.stage) begin
            r_res.status_code     <= i_cmd.st_status;
            r_res.found_index     <= st_idx;
            r_res.is_active       <= 1'b0;
            r_res.is_future       <= 1'b0;
            r_res.is_feasible     <= 1'b0;
            r_res.usable_capacity <= '0;
            r_res.earliest_start  <= '0;
            r_res.arrive_time     <= '0;
            r_res.last_result     <= i_cmd.st_last;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.emit) begin
            o_out_item <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;

    assign o_stat.op         = r_item.opcode;
    assign o_stat.full       = r_count == cpt_pkg::CNT_W'(cpt_pkg::TABLE_DEPTH);
    assign o_stat.count_zero = r_count == '0;
    assign o_stat.bad_idx    = {1'b0, r_item.entry_index} >= cpt_pkg::CMP_W'(r_count);
    assign o_stat.match_pair = (ct_rd.src == r_item.source_node) &&
                               (ct_rd.dst == r_item.dest_node);
    assign o_stat.match_src  = ct_rd.src == r_item.source_node;
    assign o_stat.scan_last  = ({1'b0, r_scan} + cpt_pkg::CNT_W'(1)) == r_count;
    assign o_stat.pend_v     = r_pend_v;
    assign o_stat.eval_done  = r_dcnt == '0;
    assign o_stat.out_free   = !r_out_valid || !i_out_stall;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= cpt_pkg::CNT_W'(cpt_pkg::TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_add_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.add_wr |-> !o_stat.full)
        else $error("append into a full table");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> o_stat.out_free)
        else $error("result overwrites an untaken transaction");

endmodule

`default_nettype wire

[sv/cpt_ctrl.sv]
// ============================================================================
// Contact plan table controller
// Sequences one transaction at a time: dispatch, table scan, evaluate, emit.
// ============================================================================
`default_nettype none

module cpt_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_stall,
    input  wire cpt_pkg::t_stat i_stat,
    output cpt_pkg::t_cmd       o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_DISP = 7'b0000010,
        S_RD   = 7'b0000100,
        S_CHK  = 7'b0001000,
        S_LFIN = 7'b0010000,
        S_EVW  = 7'b0100000,
        S_EMIT = 7'b1000000
    } t_state;

    t_state r_state, n_state, r_ret, n_ret;

    assign o_stall = r_state != S_IDLE;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_ret   = r_ret;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISP;
                end
            end
            S_DISP: begin
                o_cmd.stage   = 1'b1;
                o_cmd.st_last = 1'b1;
                n_ret         = S_IDLE;
                n_state       = S_EMIT;
                case (i_stat.op)
                    cpt_pkg::OP_CLEAR: begin
                        o_cmd.clr_count = 1'b1;
                        o_cmd.st_status = cpt_pkg::ST_OK;
                        o_cmd.st_idx    = cpt_pkg::IX_ZERO;
                    end
                    cpt_pkg::OP_ADD: begin
                        if (i_stat.full) begin
                            o_cmd.st_status = cpt_pkg::ST_FULL;
                            o_cmd.st_idx    = cpt_pkg::IX_ZERO;
                        end else begin
                            o_cmd.add_wr    = 1'b1;
                            o_cmd.st_status = cpt_pkg::ST_OK;
                            o_cmd.st_idx    = cpt_pkg::IX_COUNT;
                        end
                    end
                    cpt_pkg::OP_LOOKUP, cpt_pkg::OP_LIST: begin
                        o_cmd.scan_clr  = 1'b1;
                        o_cmd.st_status = cpt_pkg::ST_NOTFOUND;
                        o_cmd.st_idx    = cpt_pkg::IX_ZERO;
                        if (!i_stat.count_zero) begin
                            o_cmd.stage = 1'b0;
                            n_state     = S_RD;
                        end
                    end
                    cpt_pkg::OP_RESERVE, cpt_pkg::OP_RELEASE,
                    cpt_pkg::OP_CONSUME: begin
                        o_cmd.st_status = cpt_pkg::ST_BADIDX;
                        o_cmd.st_idx    = cpt_pkg::IX_ENTRY;
                        if (!i_stat.bad_idx) begin
                            o_cmd.stage = 1'b0;
                            n_state     = S_RD;
                        end
                    end
                    default: begin
                        o_cmd.stage = 1'b0;
                        n_state     = S_IDLE;
                    end
                endcase
            end
            S_RD: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                case (i_stat.op)
                    cpt_pkg::OP_LOOKUP: begin
                        if (i_stat.match_pair) begin
                            o_cmd.eval_load = 1'b1;
                            n_state         = S_EVW;
                        end else if (i_stat.scan_last) begin
                            o_cmd.stage     = 1'b1;
                            o_cmd.st_status = cpt_pkg::ST_NOTFOUND;
                            o_cmd.st_idx    = cpt_pkg::IX_ZERO;
                            o_cmd.st_last   = 1'b1;
                            n_ret           = S_IDLE;
                            n_state         = S_EMIT;
                        end else begin
                            o_cmd.scan_inc = 1'b1;
                            n_state        = S_RD;
                        end
                    end
                    cpt_pkg::OP_LIST: begin
                        // hold one match back so the final one can carry the last flag
                        o_cmd.scan_inc = !i_stat.scan_last;
                        n_state        = i_stat.scan_last ? S_LFIN : S_RD;
                        if (i_stat.match_src) begin
                            o_cmd.pend_set = 1'b1;
                            if (i_stat.pend_v) begin
                                o_cmd.stage     = 1'b1;
                                o_cmd.st_status = cpt_pkg::ST_OK;
                                o_cmd.st_idx    = cpt_pkg::IX_PEND;
                                n_ret           = i_stat.scan_last ? S_LFIN : S_RD;
                                n_state         = S_EMIT;
                            end
                        end
                    end
                    default: begin
                        o_cmd.upd_wr    = 1'b1;
                        o_cmd.stage     = 1'b1;
                        o_cmd.st_status = cpt_pkg::ST_OK;
                        o_cmd.st_idx    = cpt_pkg::IX_ENTRY;
                        o_cmd.st_last   = 1'b1;
                        n_ret           = S_IDLE;
                        n_state         = S_EMIT;
                    end
                endcase
            end
            S_LFIN: begin
                o_cmd.stage   = 1'b1;
                o_cmd.st_last = 1'b1;
                if (i_stat.pend_v) begin
                    o_cmd.st_status = cpt_pkg::ST_OK;
                    o_cmd.st_idx    = cpt_pkg::IX_PEND;
                end else begin
                    o_cmd.st_status = cpt_pkg::ST_NOTFOUND;
                    o_cmd.st_idx    = cpt_pkg::IX_ZERO;
                end
                n_ret   = S_IDLE;
                n_state = S_EMIT;
            end
            S_EVW: begin
                if (i_stat.eval_done) begin
                    o_cmd.stage_eval = 1'b1;
                    n_ret            = S_IDLE;
                    n_state          = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = r_ret;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
        end
    end

    a_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state register not one-hot");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == S_DISP))
        else $error("accepted transaction not dispatched");

    a_emit_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> (r_state == S_EMIT))
        else $error("result emitted outside the emit state");

endmodule

`default_nettype wire

[sv/contact_plan_table_engine.sv]
// ============================================================================
// Contact plan table engine
// Table of link contacts with per-entry byte counters; append, lookup, list
// and counter update transactions, one at a time.
// ============================================================================
// Sequence: clear, add and a bad-index update go from dispatch straight to emit;
// a good update reads and checks its entry first; a lookup reads and checks each
// entry scanned, then on a hit waits for the 32-step restoring divider; a list
// emits each match after the first while the scan goes on. Output stalls add waiting.
// Throughput: one transaction in flight; input stalled until its last result
// has been registered. Reset clears the entry count, scan, output valid and controller state; RAMs stay undefined.
// ============================================================================
`default_nettype none

module contact_plan_table_engine (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // request transactions
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire cpt_pkg::t_in_item  i_data,
    // result transactions
    output logic                    o_valid,
    input  wire logic               i_stall,
    output cpt_pkg::t_out_item      o_data
);

    cpt_pkg::t_cmd  cmd;
    cpt_pkg::t_stat stat;

    // Controller: owns the handshake on the request side and sequences
    // dispatch, the linear table scan, the lookup evaluation and the emit.
    cpt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // Datapath: table RAMs, arithmetic and the output register, which lets a
    // finished result wait while the scan goes on.
    cpt_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_item      (i_data),
        .i_out_stall (i_stall),
        .o_out_valid (o_valid),
        .o_out_item  (o_data)
    );

endmodule

`default_nettype wire

[bench/tb_contact_plan_table_engine.sv]
// ============================================================================
// Contact plan table engine testbench
// Drives append, lookup, list and counter update transactions with random
// idling on both sides, predicts every result from a model of the table held
// here, and checks each result field by field in order.
// ============================================================================
`timescale 1ns / 1ps

// Contact table model and queue of predicted results
class contact_scoreboard;
    cpt_pkg::t_contact  contacts [cpt_pkg::TABLE_DEPTH];
    cpt_pkg::t_ctr      counters [cpt_pkg::TABLE_DEPTH];
    int                 count;
    cpt_pkg::t_out_item pending [$];
    int                 errors;

    function void clear_table();
        count = 0;
    endfunction

    function cpt_pkg::t_out_item plain_result(logic [1:0] st, logic [5:0] ix, logic last);
        cpt_pkg::t_out_item r;
        r = '0;
        r.status_code = st;
        r.found_index = ix;
        r.last_result = last;
        return r;
    endfunction

    function logic [47:0] sat_add48(logic [47:0] a, logic [31:0] b);
        logic [48:0] s;
        s = {1'b0, a} + 49'(b);
        return s[48] ? 48'hFFFF_FFFF_FFFF : s[47:0];
    endfunction

    function logic [47:0] drop48(logic [47:0] a, logic [31:0] b);
        return (a > 48'(b)) ? a - 48'(b) : 48'd0;
    endfunction

    function cpt_pkg::t_out_item lookup_result(int i, logic [31:0] now, logic [31:0] sz);
        cpt_pkg::t_out_item r;
        logic [63:0] left;
        logic signed [63:0] cap;
        logic [63:0] es, arr;
        r = plain_result(cpt_pkg::ST_OK, i[5:0], 1'b1);
        r.is_active = (contacts[i].st <= now) && (now < contacts[i].en);
        r.is_future = now < contacts[i].st;
        left = (contacts[i].en > now) ? 64'(contacts[i].en - now) : 64'd0;
        // rate is 24 bits and left 32, so the product fits in 56 bits
        cap = $signed(64'(contacts[i].rt) * left) - $signed({16'd0, counters[i].used})
              - $signed({16'd0, counters[i].rsv});
        r.is_feasible = r.is_active && (cap >= $signed({32'd0, sz}));
        if (cap > 64'sh7FFF_FFFF_FFFF) r.usable_capacity = 48'h7FFF_FFFF_FFFF;
        else if (cap < -64'sh8000_0000_0000) r.usable_capacity = 48'h8000_0000_0000;
        else r.usable_capacity = cap[47:0];
        es = (now > contacts[i].st) ? 64'(now) : 64'(contacts[i].st);
        r.earliest_start = es[31:0];
        if (contacts[i].rt == 0) arr = 64'hFFFF_FFFF;
        else begin
            arr = es + 64'(sz) / 64'(contacts[i].rt) + 64'(contacts[i].lt);
            if (arr > 64'hFFFF_FFFF) arr = 64'hFFFF_FFFF;
        end
        r.arrive_time = arr[31:0];
        return r;
    endfunction

    function void note_request(cpt_pkg::t_in_item it);
        int k;
        int ix;
        ix = it.entry_index;
        case (it.opcode)
            cpt_pkg::OP_CLEAR: begin
                count = 0;
                pending.push_back(plain_result(cpt_pkg::ST_OK, 6'd0, 1'b1));
            end
            cpt_pkg::OP_ADD: begin
                if (count >= cpt_pkg::TABLE_DEPTH) begin
                    pending.push_back(plain_result(cpt_pkg::ST_FULL, 6'd0, 1'b1));
                end else begin
                    contacts[count] = '{it.source_node, it.dest_node, it.window_start,
                                        it.window_end, it.link_rate, it.light_time};
                    counters[count] = '0;
                    pending.push_back(plain_result(cpt_pkg::ST_OK, count[5:0], 1'b1));
                    count++;
                end
            end
            cpt_pkg::OP_LOOKUP: begin
                k = -1;
                for (int i = 0; i < count; i++)
                    if (k < 0 && contacts[i].src == it.source_node &&
                        contacts[i].dst == it.dest_node) k = i;
                if (k < 0) pending.push_back(plain_result(cpt_pkg::ST_NOTFOUND, 6'd0, 1'b1));
                else pending.push_back(lookup_result(k, it.now_time, it.size_bytes));
            end
            cpt_pkg::OP_LIST: begin
                k = 0;
                for (int i = 0; i < count; i++)
                    if (contacts[i].src == it.source_node) begin
                        pending.push_back(plain_result(cpt_pkg::ST_OK, i[5:0], 1'b0));
                        k++;
                    end
                if (k == 0) pending.push_back(plain_result(cpt_pkg::ST_NOTFOUND, 6'd0, 1'b1));
                else pending[$].last_result = 1'b1;
            end
            cpt_pkg::OP_RESERVE, cpt_pkg::OP_RELEASE, cpt_pkg::OP_CONSUME: begin
                if (ix >= count) begin
                    pending.push_back(plain_result(cpt_pkg::ST_BADIDX, it.entry_index, 1'b1));
                end else begin
                    if (it.opcode == cpt_pkg::OP_RESERVE)
                        counters[ix].rsv = sat_add48(counters[ix].rsv, it.size_bytes);
                    else if (it.opcode == cpt_pkg::OP_RELEASE)
                        counters[ix].rsv = drop48(counters[ix].rsv, it.size_bytes);
                    else begin
                        counters[ix].used = sat_add48(counters[ix].used, it.size_bytes);
                        counters[ix].rsv  = drop48(counters[ix].rsv, it.size_bytes);
                    end
                    pending.push_back(plain_result(cpt_pkg::ST_OK, it.entry_index, 1'b1));
                end
            end
            default: ;  // unused opcode gives nothing
        endcase
    endfunction

    function void check_result(cpt_pkg::t_out_item got);
        cpt_pkg::t_out_item e;
        if (pending.size() == 0) begin
            $error("unexpected result %p", got);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (got.status_code !== e.status_code) begin
            $error("status_code exp %0d got %0d", e.status_code, got.status_code); errors++;
        end
        if (got.found_index !== e.found_index) begin
            $error("found_index exp %0d got %0d", e.found_index, got.found_index); errors++;
        end
        if (got.is_active !== e.is_active) begin
            $error("is_active exp %0d got %0d", e.is_active, got.is_active); errors++;
        end
        if (got.is_future !== e.is_future) begin
            $error("is_future exp %0d got %0d", e.is_future, got.is_future); errors++;
        end
        if (got.is_feasible !== e.is_feasible) begin
            $error("is_feasible exp %0d got %0d", e.is_feasible, got.is_feasible); errors++;
        end
        if (got.usable_capacity !== e.usable_capacity) begin
            $error("usable_capacity exp %0d got %0d", e.usable_capacity,
                   got.usable_capacity); errors++;
        end
        if (got.earliest_start !== e.earliest_start) begin
            $error("earliest_start exp %0d got %0d", e.earliest_start,
                   got.earliest_start); errors++;
        end
        if (got.arrive_time !== e.arrive_time) begin
            $error("arrive_time exp %0d got %0d", e.arrive_time, got.arrive_time);
            errors++;
        end
        if (got.last_result !== e.last_result) begin
            $error("last_result exp %0d got %0d", e.last_result, got.last_result); errors++;
        end
    endfunction
endclass

module tb_contact_plan_table_engine;

    localparam int CYCLE_LIMIT = 400000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_stall;
    cpt_pkg::t_in_item  req_data = '0;
    logic               rsp_valid;
    logic               rsp_stall = 1'b0;
    cpt_pkg::t_out_item rsp_data;

    contact_scoreboard table_sb = new();

    // idling is switched off for the closing stretch of the run
    bit        calm = 1'b0;
    // long receiver hold-off requested by the stimulus
    bit        hold_req = 1'b0;
    int        cycles = 0;

    // node ids drawn from a small pool so lookups and lists actually hit
    logic [15:0] nodes [4] = '{16'h0000, 16'hFFFF, 16'h5A5A, 16'h0001};

    always #5 i_clk = ~i_clk;

    contact_plan_table_engine i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (req_valid),
        .o_stall (req_stall),
        .i_data  (req_data),
        .o_valid (rsp_valid),
        .i_stall (rsp_stall),
        .o_data  (rsp_data)
    );

    // Accepted transactions, both sides, sampled at the rising edge
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && req_valid && !req_stall) table_sb.note_request(req_data);
        if (i_rst_n && rsp_valid && !rsp_stall) table_sb.check_result(rsp_data);
    end

    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver: random stall bursts, or one long hold-off on request
    initial begin : receiver
        int n;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                rsp_stall <= 1'b1;
                repeat (300) @(negedge i_clk);
                hold_req = 1'b0;
                rsp_stall <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 6);
                rsp_stall <= 1'b1;
                repeat (n) @(negedge i_clk);
                rsp_stall <= 1'b0;
            end
        end
    end

    // One request: offer at the falling edge, hold until accepted; valid only
    // drops when an idle gap follows
    task automatic send_request(cpt_pkg::t_in_item it);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 6);
            req_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_data  <= it;
        req_valid <= 1'b1;
        @(posedge i_clk);
        while (req_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic cpt_pkg::t_in_item random_request(logic [2:0] op);
        cpt_pkg::t_in_item it;
        it = cpt_pkg::t_in_item'($bits(cpt_pkg::t_in_item)'({$urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom, $urandom}));
        it.opcode      = op;
        it.source_node = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                     : nodes[$urandom_range(0, 3)];
        it.dest_node   = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                                     : nodes[$urandom_range(0, 3)];
        it.entry_index = ($urandom_range(0, 5) == 0) ? 6'($urandom)
                          : 6'($urandom_range(0, (table_sb.count > 0) ?
                                                  table_sb.count - 1 : 0));
        // keep times and rates moderate most of the time so windows matter
        if ($urandom_range(0, 2) != 0) begin
            it.window_start = $urandom_range(0, 1000);
            it.window_end   = it.window_start + $urandom_range(0, 1000);
            it.now_time     = $urandom_range(0, 2200);
            it.link_rate    = 24'($urandom_range(0, 2000));
            it.light_time   = $urandom_range(0, 100);
            it.size_bytes   = $urandom_range(0, 500000);
        end
        return it;
    endfunction

    function automatic cpt_pkg::t_in_item make_add(logic [15:0] s, logic [15:0] d,
                                                   logic [31:0] st, logic [31:0] en,
                                                   logic [23:0] rt, logic [31:0] lt);
        cpt_pkg::t_in_item it;
        it = '0;
        it.opcode = cpt_pkg::OP_ADD;
        it.source_node = s; it.dest_node = d;
        it.window_start = st; it.window_end = en; it.link_rate = rt; it.light_time = lt;
        return it;
    endfunction

    function automatic cpt_pkg::t_in_item make_op(logic [2:0] op, logic [5:0] ix,
                                                  logic [15:0] s, logic [15:0] d,
                                                  logic [31:0] now, logic [31:0] sz);
        cpt_pkg::t_in_item it;
        it = '0;
        it.opcode = op; it.entry_index = ix;
        it.source_node = s; it.dest_node = d; it.now_time = now; it.size_bytes = sz;
        return it;
    endfunction

    initial begin : stimulus
        int r;
        logic [2:0] op;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty table cases, extremes, every opcode
        send_request(make_op(cpt_pkg::OP_LOOKUP, 0, 16'h0000, 16'hFFFF, 0, 0));
        send_request(make_op(cpt_pkg::OP_LIST, 0, 16'hFFFF, 0, 0, 0));
        send_request(make_op(cpt_pkg::OP_RESERVE, 6'd63, 0, 0, 0, 32'hFFFF_FFFF));
        send_request(make_add(16'hFFFF, 16'h0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                              24'hFF_FFFF, 32'hFFFF_FFFF));
        send_request(make_add(16'h0000, 16'hFFFF, 0, 32'hFFFF_FFFF, 24'hFF_FFFF, 0));
        send_request(make_add(16'h0000, 16'h0001, 100, 200, 0, 7));
        send_request(make_op(cpt_pkg::OP_LOOKUP, 0, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF,
                             32'hFFFF_FFFF));
        send_request(make_op(cpt_pkg::OP_LOOKUP, 0, 16'h0000, 16'hFFFF, 0,
                             32'hFFFF_FFFF));
        send_request(make_op(cpt_pkg::OP_LOOKUP, 0, 16'h0000, 16'h0001, 150, 10));
        send_request(make_op(cpt_pkg::OP_LOOKUP, 0, 16'h0000, 16'h0001, 50, 10));
        send_request(make_op(cpt_pkg::OP_LIST, 0, 16'h0000, 0, 0, 0));
        // counters: grow used, drive capacity negative, floor reserve at zero
        repeat (3) send_request(make_op(cpt_pkg::OP_CONSUME, 6'd1, 0, 0, 0, 32'hFFFF_FFFF));
        send_request(make_op(cpt_pkg::OP_RESERVE, 6'd2, 0, 0, 0, 32'hFFFF_FFFF));
        send_request(make_op(cpt_pkg::OP_RELEASE, 6'd2, 0, 0, 0, 32'd5));
        send_request(make_op(cpt_pkg::OP_RELEASE, 6'd2, 0, 0, 0, 32'hFFFF_FFFF));
        send_request(make_op(cpt_pkg::OP_CONSUME, 6'd2, 0, 0, 0, 32'd1000));
        send_request(make_op(cpt_pkg::OP_LOOKUP, 0, 16'h0000, 16'h0001, 120, 0));
        send_request(make_op(cpt_pkg::OP_RELEASE, 6'd3, 0, 0, 0, 1));
        send_request(make_op(cpt_pkg::OP_NONE, 0, 0, 0, 0, 0));
        send_request(make_op(cpt_pkg::OP_CLEAR, 0, 0, 0, 0, 0));
        send_request(make_op(cpt_pkg::OP_LOOKUP, 0, 16'h0000, 16'h0001, 0, 0));

        // Fill the table to the top, with the receiver held off part of the way
        hold_req = 1'b1;
        for (int i = 0; i < cpt_pkg::TABLE_DEPTH; i++)
            send_request(random_request(cpt_pkg::OP_ADD));
        send_request(random_request(cpt_pkg::OP_ADD));
        send_request(make_op(cpt_pkg::OP_LIST, 0, nodes[$urandom_range(0, 3)], 0, 0, 0));

        // Random mix; the closing part runs without idling
        for (int n = 0; n < 82; n++) begin
            if (n == 65) calm = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 3) op = cpt_pkg::OP_CLEAR;
            else if (r < 25) op = cpt_pkg::OP_ADD;
            else if (r < 50) op = cpt_pkg::OP_LOOKUP;
            else if (r < 60) op = cpt_pkg::OP_LIST;
            else if (r < 72) op = cpt_pkg::OP_RESERVE;
            else if (r < 84) op = cpt_pkg::OP_RELEASE;
            else if (r < 97) op = cpt_pkg::OP_CONSUME;
            else op = cpt_pkg::OP_NONE;
            send_request(random_request(op));
        end
        req_valid <= 1'b0;

        while (table_sb.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (table_sb.errors == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

endmodule
